FILE: rtl/tpc_pkg.sv
// Shared types, defaults and codes for the trie prefix counter.
`default_nettype none

package tpc_pkg;

   // Default sizing of the node pool and counters
   localparam int MAX_NODES_DEF  = 4096;
   localparam int ALPHABET_DEF   = 26;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed field widths of the request and response beats
   localparam int LETTER_BITS    = 5;
   localparam int COUNT_OUT_BITS = 16;

   // Request kind codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [LETTER_BITS-1:0] letter;
      logic                   last_letter;
   } tpc_req_type;

   typedef struct packed {
      logic [COUNT_OUT_BITS-1:0] prefix_count;
      logic                      pool_full;
   } tpc_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // capture request beat, read child link
      logic node_rd;   // read node record of the linked child
      logic commit;    // apply letter, write back, finish word
   } tpc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic skip;      // letter has no effect, no memory walk needed
   } tpc_status_type;

endpackage

`default_nettype wire

FILE: rtl/tpc_ctrl.sv
// Sequencing state machine for one letter walk step.
`default_nettype none

module tpc_ctrl
   import tpc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   input  wire tpc_status_type status,
   output tpc_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LINK,
      ST_NODE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode commands and next state
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            if (status.skip) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = ST_NODE;
            end
         end
         ST_NODE: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tpc_datapath.sv
// Node pool memories, walk registers and result register of the trie.
`default_nettype none

module tpc_datapath
   import tpc_pkg::*;
#(
   parameter int MAX_NODES  = MAX_NODES_DEF,
   parameter int ALPHABET   = ALPHABET_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire tpc_cmd_type    cmd,
   output tpc_status_type      status,
   input  wire tpc_req_type    req_data,
   output logic                rsp_valid,
   output tpc_rsp_type         rsp_data
);

   localparam int NODE_BITS  = $clog2(MAX_NODES);
   localparam int FREE_BITS  = $clog2(MAX_NODES + 1);
   localparam int SLOT_DEPTH = MAX_NODES * ALPHABET;
   localparam int SLOT_BITS  = $clog2(SLOT_DEPTH);
   localparam int WIDE_BITS  = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;

   localparam logic [SLOT_BITS-1:0] ALPHA_SLOT = SLOT_BITS'(ALPHABET);
   localparam logic [FREE_BITS-1:0] POOL_END   = FREE_BITS'(MAX_NODES);

   // Node record: back pointer to parent and letter, plus pass-through count
   typedef struct packed {
      logic [NODE_BITS-1:0]   parent;
      logic [LETTER_BITS-1:0] letter;
      logic [COUNT_BITS-1:0]  count;
   } node_rec_type;

   // Memories: links are trusted only when the child's record points back
   logic [NODE_BITS-1:0] child_links [SLOT_DEPTH];
   node_rec_type         node_info   [MAX_NODES];

   // Request and walk state
   tpc_req_type          req_ff;
   logic                 skip_ff,     skip_in;
   logic [SLOT_BITS-1:0] slot_ff,     slot_in;
   logic [NODE_BITS-1:0] link_q_ff;
   node_rec_type         info_q_ff;
   logic [NODE_BITS-1:0] cursor_ff,   cursor_in;
   logic [COUNT_BITS-1:0] cur_cnt_ff, cur_cnt_in;
   logic [FREE_BITS-1:0] next_free_ff, next_free_in;
   logic                 missed_ff,   missed_in;
   logic                 overflow_ff, overflow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tpc_rsp_type          rsp_ff,      rsp_in;

   // Memory write controls
   logic                 link_we;
   logic                 info_we;
   logic [NODE_BITS-1:0] info_wa;
   node_rec_type         info_wd;

   logic                 hit;
   logic [COUNT_BITS-1:0] inc_cnt;
   logic [WIDE_BITS-1:0] cnt_wide;
   logic                 flag_end;

   // Decide skip and link slot for an incoming beat
   assign skip_in = missed_ff | overflow_ff | (32'(req_data.letter) >= ALPHABET);
   assign slot_in = SLOT_BITS'(cursor_ff) * ALPHA_SLOT + SLOT_BITS'(req_data.letter);

   assign status.skip = skip_ff;

   // Capture request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_data;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else if (cmd.load) begin
         skip_ff <= skip_in;
      end
   end

   // Child link memory: registered read, write on allocate
   always_ff @(posedge clock) begin
      if (cmd.load && !skip_in) begin
         link_q_ff <= child_links[slot_in];
      end
      if (link_we) begin
         child_links[slot_ff] <= next_free_ff[NODE_BITS-1:0];
      end
   end

   // Node record memory: registered read, write on visit or allocate
   always_ff @(posedge clock) begin
      if (cmd.node_rd) begin
         info_q_ff <= node_info[link_q_ff];
      end
      if (info_we) begin
         node_info[info_wa] <= info_wd;
      end
   end

   // Check the link against the pool fill and the child's back pointer
   assign hit = (link_q_ff != '0)
              && (FREE_BITS'(link_q_ff) < next_free_ff)
              && (info_q_ff.parent == cursor_ff)
              && (info_q_ff.letter == req_ff.letter);

   assign inc_cnt = (info_q_ff.count == '1) ? info_q_ff.count
                                            : info_q_ff.count + COUNT_BITS'(1);

   // Apply one letter and finish the word on its last beat
   always_comb begin
      cursor_in    = cursor_ff;
      cur_cnt_in   = cur_cnt_ff;
      next_free_in = next_free_ff;
      missed_in    = missed_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      link_we      = 1'b0;
      info_we      = 1'b0;
      info_wa      = link_q_ff;
      info_wd      = info_q_ff;
      cnt_wide     = '0;
      flag_end     = 1'b0;

      if (cmd.commit) begin
         if (!skip_ff) begin
            if (req_ff.req_type == REQ_QUERY) begin
               if (hit) begin
                  cursor_in  = link_q_ff;
                  cur_cnt_in = info_q_ff.count;
               end else begin
                  missed_in = 1'b1;
               end
            end else if (hit) begin
               cursor_in     = link_q_ff;
               cur_cnt_in    = inc_cnt;
               info_we       = 1'b1;
               info_wd.count = inc_cnt;
            end else if (next_free_ff >= POOL_END) begin
               overflow_in = 1'b1;
            end else begin
               link_we        = 1'b1;
               info_we        = 1'b1;
               info_wa        = next_free_ff[NODE_BITS-1:0];
               info_wd.parent = cursor_ff;
               info_wd.letter = req_ff.letter;
               info_wd.count  = COUNT_BITS'(1);
               cursor_in      = next_free_ff[NODE_BITS-1:0];
               cur_cnt_in     = COUNT_BITS'(1);
               next_free_in   = next_free_ff + FREE_BITS'(1);
            end
         end

         // Emit the result beat and return the walk to the root
         if (req_ff.last_letter) begin
            cnt_wide     = WIDE_BITS'(cur_cnt_in);
            flag_end     = missed_in | overflow_in;
            rsp_valid_in = 1'b1;
            if (req_ff.req_type == REQ_QUERY) begin
               rsp_in.prefix_count = flag_end ? '0 : cnt_wide[COUNT_OUT_BITS-1:0];
               rsp_in.pool_full    = 1'b0;
            end else begin
               rsp_in.prefix_count = cnt_wide[COUNT_OUT_BITS-1:0];
               rsp_in.pool_full    = overflow_in;
            end
            cursor_in   = '0;
            cur_cnt_in  = '0;
            missed_in   = 1'b0;
            overflow_in = 1'b0;
         end
      end
   end

   // Hold walk state and result
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         cur_cnt_ff   <= '0;
         next_free_ff <= FREE_BITS'(1);
         missed_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         cur_cnt_ff   <= cur_cnt_in;
         next_free_ff <= next_free_in;
         missed_ff    <= missed_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/trie_prefix_counter.sv
// Top level of the trie prefix counter: controller plus node pool datapath.
//
// Words and prefixes arrive one letter per beat, taken when start is high and
// busy is low. A letter that walks the trie reads its child link, then its node
// record, then writes back; a letter that has no effect (out of range, or
// after a miss or pool overflow in the same word) skips the node record read.
// The two dependent reads of the link and node memories set this sequence. The
// beat with last_letter set produces one result beat on rsp_valid in the
// cycle in which busy drops; the receiver cannot stall it, so it must take it
// then. No clearing pass is needed after reset: a child link counts only when
// the child is already allocated and its node record points back to the
// parent and letter, so items may start in the first cycle after reset.
`default_nettype none

module trie_prefix_counter
   import tpc_pkg::*;
#(
   parameter int MAX_NODES  = MAX_NODES_DEF,
   parameter int ALPHABET   = ALPHABET_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire tpc_req_type req_data,
   output logic             rsp_valid,
   output tpc_rsp_type      rsp_data
);

   tpc_cmd_type    cmd;
   tpc_status_type status;

   // Sequence each letter
   tpc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Walk the node pool
   tpc_datapath #(
      .MAX_NODES  (MAX_NODES),
      .ALPHABET   (ALPHABET),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: tb/trie_count_checker.sv
// Checker for the trie prefix counter: tracks the trie, predicts and compares result beats.

module trie_count_checker
   import tpc_pkg::*;
#(
   parameter int MAX_NODES  = MAX_NODES_DEF,
   parameter int ALPHABET   = ALPHABET_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  tpc_req_type req_data,
   input  logic        rsp_valid,
   input  tpc_rsp_type rsp_data,
   output int          error_count,
   output int          pending_results
);

   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

   // Shadow trie: child index per (node, letter), 0 means no child
   int unsigned     child_of [MAX_NODES*ALPHABET];
   longint unsigned words_through [MAX_NODES];
   int unsigned     next_node;
   int unsigned     walk_node;
   bit              walk_missed;
   bit              walk_overflow;

   tpc_rsp_type expected_results [$];
   tpc_rsp_type oldest;
   int          mismatches = 0;

   // Empty the trie and put the walk back at the root
   function automatic void clear_trie();
      foreach (child_of[i]) child_of[i] = 0;
      foreach (words_through[i]) words_through[i] = 0;
      next_node     = 1;
      walk_node     = 0;
      walk_missed   = 1'b0;
      walk_overflow = 1'b0;
      expected_results.delete();
   endfunction

   // Walk one letter beat; queue a result when the beat ends a word
   function automatic void walk_beat(tpc_req_type beat);
      longint unsigned slot;
      int unsigned     child;
      tpc_rsp_type     result;
      if (!walk_missed && !walk_overflow && beat.letter < ALPHABET) begin
         slot  = longint'(walk_node) * ALPHABET + beat.letter;
         child = child_of[slot];
         if (beat.req_type == REQ_QUERY) begin
            if (child == 0) walk_missed = 1'b1;
            else walk_node = child;
         end else begin
            // Allocate a node for a missing link unless the pool is used up
            if (child == 0) begin
               if (next_node >= MAX_NODES) begin
                  walk_overflow = 1'b1;
               end else begin
                  child          = next_node;
                  next_node      = next_node + 1;
                  child_of[slot] = child;
               end
            end
            if (!walk_overflow) begin
               walk_node = child;
               if (words_through[child] < COUNT_MAX)
                  words_through[child] = words_through[child] + 1;
            end
         end
      end
      if (beat.last_letter) begin
         result.prefix_count = COUNT_OUT_BITS'(words_through[walk_node]);
         result.pool_full    = 1'b0;
         if (beat.req_type == REQ_QUERY) begin
            if (walk_missed || walk_overflow) result.prefix_count = '0;
         end else begin
            result.pool_full = walk_overflow;
         end
         expected_results.push_back(result);
         walk_node     = 0;
         walk_missed   = 1'b0;
         walk_overflow = 1'b0;
      end
   endfunction

   // Take request beats first, then check any result beat against the oldest one
   always @(posedge clock) begin
      if (reset) begin
         clear_trie();
      end else begin
         if (start && !busy) walk_beat(req_data);
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with none expected: count %0d pool_full %0b",
                        $time, rsp_data.prefix_count, rsp_data.pool_full);
               mismatches++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_data.prefix_count !== oldest.prefix_count) begin
                  $display("%0t: prefix_count expected %0d actual %0d",
                           $time, oldest.prefix_count, rsp_data.prefix_count);
                  mismatches++;
               end
               if (rsp_data.pool_full !== oldest.pool_full) begin
                  $display("%0t: pool_full expected %0b actual %0b",
                           $time, oldest.pool_full, rsp_data.pool_full);
                  mismatches++;
               end
            end
         end
      end
      error_count     <= mismatches;
      pending_results <= expected_results.size();
   end

endmodule

FILE: tb/trie_prefix_counter_test.sv
// Top of the trie prefix counter test: clock, reset, letter stimulus and verdict.

module trie_prefix_counter_test;
   import tpc_pkg::*;

   localparam int     MAX_WORD         = 12;
   localparam int     WORD_BITS        = MAX_WORD * LETTER_BITS;
   localparam int     LOG_DEPTH        = 64;
   localparam int     RANDOM_ITEMS     = 600;
   localparam int     LATE_ITEMS       = 100;
   localparam longint TIMEOUT_CYCLES   = 4_000_000;

   // Letter codes used by the directed beats
   localparam logic [LETTER_BITS-1:0] LTR_A     = 5'd0;
   localparam logic [LETTER_BITS-1:0] LTR_B     = 5'd1;
   localparam logic [LETTER_BITS-1:0] LTR_C     = 5'd2;
   localparam logic [LETTER_BITS-1:0] LTR_Q     = 5'd16;
   localparam logic [LETTER_BITS-1:0] LTR_Z     = 5'd25;
   localparam logic [LETTER_BITS-1:0] LTR_OUT_1 = 5'd26;
   localparam logic [LETTER_BITS-1:0] LTR_OUT_2 = 5'd30;
   localparam logic [LETTER_BITS-1:0] LTR_OUT_3 = 5'd31;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   tpc_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   tpc_rsp_type rsp_data;
   int          error_count;
   int          pending_results;

   // Recently inserted words, reused to build queries and repeat inserts
   bit [WORD_BITS-1:0] word_log [LOG_DEPTH];
   int                 word_log_len [LOG_DEPTH];
   int                 word_log_fill = 0;
   int                 items_sent    = 0;
   bit                 allow_gaps    = 1'b1;

   always #10 clock = ~clock;

   trie_prefix_counter u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   trie_count_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   // Mostly back to back or short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      if (!allow_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Mostly valid letters, a few out of range
   function automatic logic [LETTER_BITS-1:0] random_letter(bit narrow);
      if ($urandom_range(0, 32) == 0) return LETTER_BITS'($urandom_range(ALPHABET_DEF, 31));
      if (narrow) return LETTER_BITS'($urandom_range(0, 3));
      return LETTER_BITS'($urandom_range(0, ALPHABET_DEF - 1));
   endfunction

   // Present one letter beat, hold it until taken, then idle for a random gap if one is picked
   task automatic send_letter(input logic kind, input logic [LETTER_BITS-1:0] idx,
                              input logic last);
      tpc_req_type beat;
      int          gap;
      beat.req_type    = kind;
      beat.letter      = idx;
      beat.last_letter = last;
      req_data <= beat;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off new beats until every result is back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // Build a word: replay a logged word prefix or make fresh letters
   task automatic send_random_word();
      bit [WORD_BITS-1:0] letters;
      int                 len;
      int                 style;
      int                 idx;
      bit                 narrow;
      logic               kind;
      logic               beat_kind;
      letters = '0;
      style   = $urandom_range(0, 99);
      kind    = (style < 45) ? REQ_INSERT : REQ_QUERY;
      if (word_log_fill > 0 &&
          $urandom_range(0, 99) < ((kind == REQ_QUERY) ? 70 : 35)) begin
         idx     = $urandom_range(0, ((word_log_fill < LOG_DEPTH) ? word_log_fill
                                                                 : LOG_DEPTH) - 1);
         len     = $urandom_range(1, word_log_len[idx]);
         letters = word_log[idx];
         // Alter the final letter sometimes to land next to a known path
         if ($urandom_range(0, 3) == 0)
            letters[(len-1)*LETTER_BITS +: LETTER_BITS] =
               LETTER_BITS'($urandom_range(0, ALPHABET_DEF - 1));
      end else begin
         len    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, MAX_WORD)
                                              : $urandom_range(1, 5);
         narrow = $urandom_range(0, 1);
         for (int i = 0; i < len; i++)
            letters[i*LETTER_BITS +: LETTER_BITS] = random_letter(narrow);
      end
      for (int i = 0; i < len; i++) begin
         beat_kind = (style >= 90) ? logic'($urandom_range(0, 1)) : kind;
         send_letter(beat_kind, letters[i*LETTER_BITS +: LETTER_BITS], i == len - 1);
      end
      if (kind == REQ_INSERT && style < 90) begin
         word_log[word_log_fill % LOG_DEPTH]     = letters;
         word_log_len[word_log_fill % LOG_DEPTH] = len;
         word_log_fill++;
      end
   endtask

   initial begin
      int target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Query on the empty trie misses
      send_letter(REQ_QUERY, LTR_A, 1'b1);
      // Build a and ab, read both back, then insert z
      send_letter(REQ_INSERT, LTR_A, 1'b1);
      send_letter(REQ_INSERT, LTR_A, 1'b0);
      send_letter(REQ_INSERT, LTR_B, 1'b1);
      send_letter(REQ_QUERY, LTR_A, 1'b1);
      send_letter(REQ_QUERY, LTR_A, 1'b0);
      send_letter(REQ_QUERY, LTR_B, 1'b1);
      send_letter(REQ_INSERT, LTR_Z, 1'b1);
      // Out-of-range letters alone end the word at the root
      send_letter(REQ_INSERT, LTR_OUT_3, 1'b1);
      send_letter(REQ_QUERY, LTR_OUT_1, 1'b1);
      // Out-of-range letter inside a word is skipped
      send_letter(REQ_INSERT, LTR_A, 1'b0);
      send_letter(REQ_INSERT, LTR_OUT_2, 1'b0);
      send_letter(REQ_INSERT, LTR_B, 1'b1);
      // Letters after a query miss do nothing
      send_letter(REQ_QUERY, LTR_C, 1'b0);
      send_letter(REQ_QUERY, LTR_A, 1'b1);
      // Mixed kinds share one walk
      send_letter(REQ_INSERT, LTR_A, 1'b0);
      send_letter(REQ_QUERY, LTR_B, 1'b1);
      send_letter(REQ_QUERY, LTR_Q, 1'b0);
      send_letter(REQ_INSERT, LTR_A, 1'b1);
      send_letter(REQ_QUERY, LTR_A, 1'b0);
      send_letter(REQ_QUERY, LTR_OUT_3, 1'b0);
      send_letter(REQ_QUERY, LTR_B, 1'b1);
      drain();

      // Random words with occasional drains
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 39) == 0) allow_gaps = !allow_gaps;
         if ($urandom_range(0, 79) == 0) drain();
         send_random_word();
      end
      drain();

      // More random words after a full drain
      target = items_sent + LATE_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 39) == 0) allow_gaps = !allow_gaps;
         send_random_word();
      end

      // Read node a, bump it once more, then read it again
      allow_gaps = 1'b1;
      send_letter(REQ_QUERY, LTR_A, 1'b1);
      send_letter(REQ_INSERT, LTR_A, 1'b1);
      send_letter(REQ_QUERY, LTR_A, 1'b1);
      repeat (20) send_random_word();

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_results == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // End a hung run
   initial begin
      #(TIMEOUT_CYCLES * 20);
      $display("== FAIL ==");
      $finish;
   end

endmodule
